// File: design/glmf_pkg.sv
// Package: shared types and constants of the grid local maximum finder.
`default_nettype none

package glmf_pkg;

    // Field widths fixed by the stream and register formats
    localparam int ROW_BITS      = 16;
    localparam int COL_OUT_BITS  = 10;
    localparam int COL_CFG_BITS  = 11;
    localparam int PIX_BITS      = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BIT   = 2;

    // Result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [ROW_BITS-1:0]     MIN_ROWS = 16'd2;
    localparam logic [COL_CFG_BITS-1:0] MIN_COLS = 11'd2;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic [PIX_BITS-1:0]     value;
    } t_peak;

endpackage

`default_nettype wire

// File: design/glmf_in_if.sv
// Interface: input stream of grid elements and flush steps.
`default_nettype none

interface glmf_in_if
    import glmf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [PIX_BITS-1:0] pixel_value;

    modport source (output valid, output operation, output pixel_value, input ready);
    modport sink (input valid, input operation, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: design/glmf_out_if.sv
// Interface: output stream of reported local maxima.
`default_nettype none

interface glmf_out_if
    import glmf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [ROW_BITS-1:0]     peak_row;
    logic [COL_OUT_BITS-1:0] peak_col;
    logic [PIX_BITS-1:0]     peak_value;

    modport source (output valid, output peak_row, output peak_col, output peak_value,
                    input ready);
    modport sink (input valid, input peak_row, input peak_col, input peak_value,
                  output ready);
endinterface

`default_nettype wire

// File: design/grid_local_maximum_finder.sv
// Timing: a peak is decided in the decision stage once the element below it (or its flush step) is
//   taken; it is then registered into the output queue, from which it can transfer.
// Throughput: one input item per cycle, set by the two-read, one-write line memory port;
//   input ready drops only while queued results plus the decision stage item reach four.
// Reset: i_rst_n is synchronous, active low; it clears positions, the queue and sets both
//   size registers to 2. The line memory is not cleared and needs no clearing pass.
`default_nettype none

module grid_local_maximum_finder
    import glmf_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    glmf_in_if.sink                  i_in,
    glmf_out_if.source               o_peak,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire [APB_ADDR_BITS-1:0]  paddr,
    input  wire [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int AW  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int CNW = AW + 1;
    localparam int VB  = VALUE_BITS;
    localparam int DW  = 2 * VALUE_BITS;

    // ---------------- configuration registers ----------------
    logic [ROW_BITS-1:0]     r_row_count;
    logic [COL_CFG_BITS-1:0] r_col_count;
    logic                    w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= MIN_ROWS;
            r_col_count <= MIN_COLS;
        end else if (w_cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_ROW_COUNT: r_row_count <= pwdata[ROW_BITS-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[COL_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_ROW_COUNT: prdata = APB_DATA_BITS'(r_row_count);
            REG_COL_COUNT: prdata = APB_DATA_BITS'(r_col_count);
            default:       prdata = '0;
        endcase
    end

    // Effective grid size: clamp to at least 2 and columns to the line capacity
    logic [ROW_BITS-1:0] w_nrows;
    logic [CNW-1:0]      w_ncols;

    assign w_nrows = (r_row_count < MIN_ROWS) ? MIN_ROWS : r_row_count;

    always_comb begin
        if (r_col_count < MIN_COLS) begin
            w_ncols = CNW'(MIN_COLS);
        end else if (32'(r_col_count) > 32'(MAX_COLS)) begin
            w_ncols = CNW'(MAX_COLS);
        end else begin
            w_ncols = CNW'(r_col_count);
        end
    end

    // ---------------- position tracking and memory read issue ----------------
    logic [ROW_BITS-1:0] r_row_pos, n_row_pos;
    logic [AW-1:0]       r_col_pos, n_col_pos;
    logic [AW-1:0]       r_flush_pos, n_flush_pos;

    logic                w_accept;
    logic                w_s0_act;
    logic                w_s0_decide;
    logic                w_s0_write;
    logic [AW-1:0]       w_s0_col;
    logic [ROW_BITS-1:0] w_s0_row;
    logic                w_s0_has_up;
    logic                w_s0_has_down;
    logic [VB-1:0]       w_pix;

    logic [FIFO_CNT_BITS-1:0] r_count;
    logic                     r_s1_valid;

    assign i_in.ready = (32'(r_count) + 32'(r_s1_valid)) < FIFO_DEPTH;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pix      = VB'(32'(i_in.pixel_value));

    always_comb begin
        logic [ROW_BITS-1:0] row_t;
        logic [AW-1:0]       col_t;
        logic                go;
        logic [CNW-1:0]      f1;

        n_row_pos     = r_row_pos;
        n_col_pos     = r_col_pos;
        n_flush_pos   = r_flush_pos;
        w_s0_act      = 1'b0;
        w_s0_decide   = 1'b0;
        w_s0_write    = 1'b0;
        w_s0_col      = r_col_pos;
        w_s0_row      = r_row_pos;
        w_s0_has_up   = 1'b0;
        w_s0_has_down = 1'b0;
        row_t         = r_row_pos;
        col_t         = r_col_pos;
        go            = 1'b0;
        f1            = CNW'(r_flush_pos);

        if (w_accept) begin
            if (i_in.operation == OP_PIXEL) begin
                if (r_row_pos < w_nrows) begin
                    go = 1'b1;
                    // column count lowered under the position: wrap to next row
                    if (CNW'(r_col_pos) >= w_ncols) begin
                        col_t = '0;
                        row_t = r_row_pos + 1'b1;
                        if (row_t >= w_nrows) begin
                            n_row_pos = row_t;
                            n_col_pos = '0;
                            go        = 1'b0;
                        end
                    end
                    if (go) begin
                        w_s0_act      = 1'b1;
                        w_s0_write    = 1'b1;
                        w_s0_col      = col_t;
                        w_s0_decide   = (row_t != '0);
                        w_s0_row      = row_t - 1'b1;
                        w_s0_has_up   = (row_t >= MIN_ROWS);
                        w_s0_has_down = 1'b1;
                        if (CNW'(col_t) + 1'b1 >= w_ncols) begin
                            n_col_pos = '0;
                            n_row_pos = row_t + 1'b1;
                        end else begin
                            n_col_pos = col_t + 1'b1;
                            n_row_pos = row_t;
                        end
                    end
                end
            end else begin
                if (r_row_pos >= w_nrows) begin
                    if (CNW'(r_flush_pos) < w_ncols) begin
                        w_s0_act    = 1'b1;
                        w_s0_decide = 1'b1;
                        w_s0_col    = r_flush_pos;
                        w_s0_row    = w_nrows - 1'b1;
                        w_s0_has_up = 1'b1;
                        f1          = CNW'(r_flush_pos) + 1'b1;
                    end
                    if (f1 >= w_ncols) begin
                        n_row_pos   = '0;
                        n_col_pos   = '0;
                        n_flush_pos = '0;
                    end else begin
                        n_flush_pos = AW'(f1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_flush_pos <= '0;
        end else begin
            r_row_pos   <= n_row_pos;
            r_col_pos   <= n_col_pos;
            r_flush_pos <= n_flush_pos;
        end
    end

    // ---------------- line memory: {older, newer} per column ----------------
    logic [DW-1:0] mem_line [MAX_COLS];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;
    logic          w_mem_we;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_s0_col_next;
    logic [AW-1:0] r_s1_col;

    assign w_s0_col_next = w_s0_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_line[r_s1_col] <= w_wdata;
        end
        if (w_s0_act) begin
            r_rd_a <= mem_line[w_s0_col];
            r_rd_b <= mem_line[w_s0_col_next];
        end
    end

    // ---------------- decision stage ----------------
    logic                r_s1_decide;
    logic                r_s1_write;
    logic [AW-1:0]       r_s1_col_next;
    logic [ROW_BITS-1:0] r_s1_row;
    logic                r_s1_has_up;
    logic                r_s1_has_down;
    logic                r_s1_has_left;
    logic                r_s1_has_right;
    logic [VB-1:0]       r_s1_value;

    logic                r_fw_valid;
    logic [AW-1:0]       r_fw_addr;
    logic [DW-1:0]       r_fw_data;
    logic [VB-1:0]       r_left;

    logic [DW-1:0]       w_ent_a;
    logic [DW-1:0]       w_ent_b;
    logic [VB-1:0]       w_center;
    logic                w_is_peak;
    logic                w_push;
    logic                w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            r_s1_valid <= w_s0_act;
            r_fw_valid <= w_mem_we;
            if (r_s1_valid && r_s1_decide) begin
                r_left <= w_center;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_decide    <= w_s0_decide;
        r_s1_write     <= w_s0_write;
        r_s1_col       <= w_s0_col;
        r_s1_col_next  <= w_s0_col_next;
        r_s1_row       <= w_s0_row;
        r_s1_has_up    <= w_s0_has_up;
        r_s1_has_down  <= w_s0_has_down;
        r_s1_has_left  <= (w_s0_col != '0);
        r_s1_has_right <= (CNW'(w_s0_col) + 1'b1 < w_ncols);
        r_s1_value     <= w_pix;
        r_fw_addr      <= r_s1_col;
        r_fw_data      <= w_wdata;
    end

    // Forward the write that landed on the same edge as this item's read
    assign w_ent_a  = (r_fw_valid && r_fw_addr == r_s1_col) ? r_fw_data : r_rd_a;
    assign w_ent_b  = (r_fw_valid && r_fw_addr == r_s1_col_next) ? r_fw_data : r_rd_b;
    assign w_center = w_ent_a[VB-1:0];

    // Shift the column: newer becomes older, the new element becomes newer
    assign w_mem_we = r_s1_valid && r_s1_write;
    assign w_wdata  = {w_center, r_s1_value};

    assign w_is_peak = (!r_s1_has_up    || w_center >= w_ent_a[DW-1:VB])
                    && (!r_s1_has_left  || w_center >= r_left)
                    && (!r_s1_has_right || w_center >= w_ent_b[VB-1:0])
                    && (!r_s1_has_down  || w_center >= r_s1_value);

    assign w_push = r_s1_valid && r_s1_decide && w_is_peak;
    assign w_pop  = o_peak.valid && o_peak.ready;

    // ---------------- output queue ----------------
    t_peak                    r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    t_peak                    w_new_peak;

    assign w_new_peak.row   = r_s1_row;
    assign w_new_peak.col   = COL_OUT_BITS'(32'(r_s1_col));
    assign w_new_peak.value = PIX_BITS'(32'(w_center));

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_new_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_peak.valid      = (r_count != '0);
    assign o_peak.peak_row   = r_fifo[r_rd_ptr].row;
    assign o_peak.peak_col   = r_fifo[r_rd_ptr].col;
    assign o_peak.peak_value = r_fifo[r_rd_ptr].value;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(r_s1_valid)) <= FIFO_DEPTH)
        else $error("result queue plus decision stage exceed queue depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (32'(r_count) < FIFO_DEPTH) || w_pop)
        else $error("peak pushed into a full result queue");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_peak.valid)
        else $error("input stalled with no result waiting");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> $past(w_accept))
        else $error("line write without an accepted element one cycle earlier");
`endif

endmodule

`default_nettype wire

// File: tb/glmf_peak_checker.sv
`timescale 1ns / 100ps
// Checker: predicts local maxima from the observed input stream and compares the output.
module glmf_peak_checker
    import glmf_pkg::*;
#(
    parameter int LINE_COLS = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    glmf_in_if                      i_in,
    glmf_out_if                     i_peak,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [APB_ADDR_BITS-1:0] paddr,
    input  wire [APB_DATA_BITS-1:0] pwdata,
    input  wire                     pready,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [ROW_BITS-1:0]     rows_cfg;
    logic [COL_CFG_BITS-1:0] cols_cfg;
    logic [PIX_BITS-1:0]     prev_line [LINE_COLS];
    logic [PIX_BITS-1:0]     last_line [LINE_COLS];
    int unsigned             next_row;
    int unsigned             next_col;
    int unsigned             flush_col;
    logic [PIX_BITS-1:0]     left_value;
    t_peak                   pending_peaks [$];
    t_peak                   want;
    int                      fails = 0;

    function automatic bit side_ok(input int unsigned c, input int unsigned ncols,
                                   input logic [PIX_BITS-1:0] mid);
        return (c == 0 || mid >= left_value) && (c + 1 >= ncols || mid >= last_line[c + 1]);
    endfunction

    task automatic report_peak(input int unsigned r, input int unsigned c,
                               input logic [PIX_BITS-1:0] mid);
        t_peak found;
        found.row   = ROW_BITS'(r);
        found.col   = COL_OUT_BITS'(c);
        found.value = mid;
        pending_peaks = {pending_peaks, found};
    endtask

    // Decide the element above the incoming one, or the next last-row element on a flush.
    task automatic find_peak(input t_op op, input logic [PIX_BITS-1:0] pix);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned c;
        logic [PIX_BITS-1:0] mid;
        nrows = (rows_cfg < MIN_ROWS) ? MIN_ROWS : rows_cfg;
        ncols = (cols_cfg < MIN_COLS) ? MIN_COLS : cols_cfg;
        if (ncols > LINE_COLS) ncols = LINE_COLS;
        if (op == OP_PIXEL) begin
            if (next_row >= nrows) return;
            if (next_col >= ncols) begin
                // columns were narrowed under a partial row: wrap now
                next_col = 0;
                next_row++;
                if (next_row >= nrows) return;
            end
            c = next_col;
            if (next_row > 0) begin
                mid = last_line[c];
                if (side_ok(c, ncols, mid) && (next_row < 2 || mid >= prev_line[c]) && mid >= pix)
                    report_peak(next_row - 1, c, mid);
                left_value = mid;
            end
            prev_line[c] = last_line[c];
            last_line[c] = pix;
            if (c + 1 >= ncols) begin
                next_col = 0;
                next_row++;
            end else begin
                next_col = c + 1;
            end
        end else begin
            // drop flushes that come before the last row is complete
            if (next_row < nrows) return;
            c = flush_col;
            if (c < ncols) begin
                mid = last_line[c];
                if (side_ok(c, ncols, mid) && mid >= prev_line[c])
                    report_peak(nrows - 1, c, mid);
                left_value = mid;
                c++;
            end
            if (c >= ncols) begin
                next_row  = 0;
                next_col  = 0;
                flush_col = 0;
            end else begin
                flush_col = c;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_cfg   = MIN_ROWS;
            cols_cfg   = MIN_COLS;
            next_row   = 0;
            next_col   = 0;
            flush_col  = 0;
            left_value = '0;
            pending_peaks.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (t_reg_idx'(paddr[REG_SEL_BIT]) == REG_ROW_COUNT) begin
                    rows_cfg = pwdata[ROW_BITS-1:0];
                end else begin
                    cols_cfg = pwdata[COL_CFG_BITS-1:0];
                end
            end
            if (i_in.valid && i_in.ready) find_peak(t_op'(i_in.operation), i_in.pixel_value);
            if (i_peak.valid && i_peak.ready) begin
                if (pending_peaks.size() == 0) begin
                    fails++;
                    $error("unexpected peak: row %0d col %0d value %0d",
                           i_peak.peak_row, i_peak.peak_col, i_peak.peak_value);
                end else begin
                    want = pending_peaks.pop_front();
                    if (i_peak.peak_row !== want.row) begin
                        fails++;
                        $error("peak_row: expected %0d, got %0d", want.row, i_peak.peak_row);
                    end
                    if (i_peak.peak_col !== want.col) begin
                        fails++;
                        $error("peak_col: expected %0d, got %0d", want.col, i_peak.peak_col);
                    end
                    if (i_peak.peak_value !== want.value) begin
                        fails++;
                        $error("peak_value: expected %0d, got %0d", want.value,
                               i_peak.peak_value);
                    end
                end
            end
        end
        o_pending    <= pending_peaks.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/tb_grid_local_maximum_finder.sv
`timescale 1ns / 100ps
// Testbench top: drives frames and register writes into the peak finder and reports the verdict.
module tb_grid_local_maximum_finder
    import glmf_pkg::*;
;

    localparam int LINE_COLS = 1024;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending;
    bit                       no_gaps;
    int unsigned              rows_now = 2;
    int unsigned              cols_now = 2;
    int unsigned              frame_items;

    glmf_in_if  in_ch ();
    glmf_out_if peak_ch ();

    grid_local_maximum_finder #(
        .MAX_COLS (LINE_COLS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_peak  (peak_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glmf_peak_checker #(
        .LINE_COLS (LINE_COLS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_peak       (peak_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: stall a random number of cycles before each transfer.
    initial begin
        int unsigned stall;
        peak_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                peak_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            peak_ch.ready <= 1'b1;
            do @(posedge clk); while (!(peak_ch.valid && peak_ch.ready));
        end
    end

    task automatic send_item(input t_op op, input logic [PIX_BITS-1:0] val, input bit counted);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.pixel_value <= val;
        do @(posedge clk); while (!in_ch.ready);
        if (counted) frame_items++;
    endtask

    // Hold input, let every pending peak drain, then write one size register.
    task automatic set_size(input t_reg_idx idx, input int unsigned val);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(idx) << REG_SEL_BIT;
        pwdata  <= APB_DATA_BITS'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_ROW_COUNT) begin
            rows_now = val;
        end else begin
            cols_now = val;
        end
    endtask

    // One full frame at the current sizes; noisy frames carry early flushes and stray pixels.
    task automatic run_frame(input int unsigned style, input bit noisy);
        int unsigned nr;
        int unsigned nc;
        int unsigned i;
        logic [PIX_BITS-1:0] v;
        nr = (rows_now < MIN_ROWS) ? MIN_ROWS : rows_now;
        nc = (cols_now < MIN_COLS) ? MIN_COLS : cols_now;
        if (nc > LINE_COLS) nc = LINE_COLS;
        for (i = 0; i < nr * nc; i++) begin
            if (noisy && $urandom_range(0, 24) == 0) send_item(OP_FLUSH, PIX_BITS'($urandom), 0);
            case (style)
                0: v = PIX_BITS'($urandom_range(0, 3));
                1: v = PIX_BITS'($urandom);
                default: v = ($urandom_range(0, 1) != 0) ? {PIX_BITS{1'b1}} : '0;
            endcase
            send_item(OP_PIXEL, v, 1);
        end
        if (noisy && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(OP_PIXEL, PIX_BITS'($urandom), 0);
        end
        for (i = 0; i < nc; i++) send_item(OP_FLUSH, PIX_BITS'($urandom), 1);
    endtask

    initial begin
        int unsigned i;
        int n;
        no_gaps           = 1'b0;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_PIXEL;
        in_ch.pixel_value <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes 2x2: a flush before any pixel is dropped, then value extremes
        send_item(OP_FLUSH, '0, 0);
        send_item(OP_PIXEL, {PIX_BITS{1'b1}}, 0);
        send_item(OP_PIXEL, '0, 0);
        send_item(OP_PIXEL, '0, 0);
        send_item(OP_PIXEL, {PIX_BITS{1'b1}}, 0);
        send_item(OP_FLUSH, '0, 0);
        send_item(OP_FLUSH, {PIX_BITS{1'b1}}, 0);

        // flat 3x2 grid (column count below minimum): every element ties, one stray pixel
        set_size(REG_ROW_COUNT, 3);
        set_size(REG_COL_COUNT, 1);
        for (i = 0; i < 6; i++) send_item(OP_PIXEL, PIX_BITS'(7), 0);
        send_item(OP_PIXEL, {PIX_BITS{1'b1}}, 0);
        send_item(OP_FLUSH, '0, 0);
        send_item(OP_FLUSH, '0, 0);

        // narrow the columns mid-flush so the last flush ends the frame silently
        set_size(REG_ROW_COUNT, 0);
        set_size(REG_COL_COUNT, 3);
        for (i = 0; i < 6; i++) send_item(OP_PIXEL, PIX_BITS'(i % 2), 0);
        send_item(OP_FLUSH, '0, 0);
        send_item(OP_FLUSH, '0, 0);
        set_size(REG_COL_COUNT, 2);
        send_item(OP_FLUSH, '0, 0);

        // clamped width, then narrow the columns under a partial row so the next pixel wraps
        set_size(REG_ROW_COUNT, 2);
        set_size(REG_COL_COUNT, 2047);
        for (i = 0; i < 5; i++) send_item(OP_PIXEL, PIX_BITS'($urandom_range(0, 3)), 0);
        set_size(REG_COL_COUNT, 3);
        for (i = 0; i < 3; i++) send_item(OP_PIXEL, PIX_BITS'($urandom_range(0, 3)), 0);
        for (i = 0; i < 3; i++) send_item(OP_FLUSH, '0, 0);

        frame_items = 0;
        while (frame_items < 1250) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    set_size(REG_ROW_COUNT, $urandom_range(2, 12));
                    set_size(REG_COL_COUNT, $urandom_range(2, 40));
                end else begin
                    set_size(REG_ROW_COUNT, $urandom_range(0, 8));
                    set_size(REG_COL_COUNT, $urandom_range(0, 12));
                end
            end
            run_frame($urandom_range(0, 2), $urandom_range(0, 3) != 0);
        end
        no_gaps = 1'b0;

        in_ch.valid <= 1'b0;
        n = 0;
        do begin
            @(posedge clk);
            n++;
        end while (pending != 0 && n < 10000);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
